/* hw/rtl/lru_page_replacement_assert.svh */
// Assertion macros for the LRU page replacement block.
// Included by the top level; no other dependencies.
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is low.
`define LRUPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LRUPR_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg)
`define LRUPR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

/* hw/rtl/lrupr_pkg.sv */
// Shared types and constants for the LRU page replacement block.
// Used by lrupr_cell, lru_page_replacement and lru_checker; no dependencies.
package lrupr_pkg;

    // Widths cover the largest supported frame count (64) and page width (32).
    localparam int PAGE_W = 32;
    localparam int RANK_W = 7;
    localparam int SLOT_W = 6;

    localparam logic [3:0] FRAMES_IN_USE_RESET = 4'd3;

    // Search item handed from cell to cell down the chain.
    typedef struct packed {
        logic              valid;
        logic [PAGE_W-1:0] page;
        logic              found;
        logic [SLOT_W-1:0] hit_slot;
        logic [RANK_W-1:0] hit_rank;
        logic              min_valid;
        logic [SLOT_W-1:0] min_slot;
        logic [RANK_W-1:0] min_rank;
        logic [PAGE_W-1:0] min_page;
    } probe_t;

    // Commit command broadcast to every cell.
    typedef struct packed {
        logic              en;
        logic              promote;
        logic              write_page;
        logic [SLOT_W-1:0] slot;
        logic [RANK_W-1:0] rank_ref;
        logic [RANK_W-1:0] new_rank;
        logic [PAGE_W-1:0] page;
    } upd_t;

endpackage

/* hw/rtl/lrupr_cell.sv */
// One page frame of the LRU chain: resident page, recency rank, search stage.
// Depends on lrupr_pkg.
module lrupr_cell #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16,
    parameter int INDEX     = 0
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [$clog2(FRAMES+1)-1:0]      nv,
    input  lrupr_pkg::probe_t                probe_in,
    output lrupr_pkg::probe_t                probe_out,
    input  lrupr_pkg::upd_t                  upd
);
    import lrupr_pkg::*;

    localparam int CW = $clog2(FRAMES + 1);

    logic [PAGE_BITS-1:0] page_reg, page_next;
    logic [CW-1:0]        rank_reg, rank_next;
    probe_t               probe_reg, probe_next;
    logic                 active;
    logic                 is_slot;

    assign active  = CW'(INDEX) < nv;
    assign is_slot = upd.slot == SLOT_W'(INDEX);

    // Fold this frame into the search: first match wins, lowest rank wins,
    // earlier slot wins a tie.
    always_comb begin
        probe_next = probe_in;
        if (probe_in.valid && active) begin
            if (!probe_in.found && probe_in.page[PAGE_BITS-1:0] == page_reg) begin
                probe_next.found    = 1'b1;
                probe_next.hit_slot = SLOT_W'(INDEX);
                probe_next.hit_rank = RANK_W'(rank_reg);
            end
            if (!probe_in.min_valid || rank_reg < probe_in.min_rank[CW-1:0]) begin
                probe_next.min_valid = 1'b1;
                probe_next.min_slot  = SLOT_W'(INDEX);
                probe_next.min_rank  = RANK_W'(rank_reg);
                probe_next.min_page  = PAGE_W'(page_reg);
            end
        end
    end

    always_comb begin
        rank_next = rank_reg;
        page_next = page_reg;
        if (upd.en) begin
            // Age every more recent active frame by one when a frame moves to the top
            if (upd.promote && active && rank_reg > upd.rank_ref[CW-1:0]) begin
                rank_next = rank_reg - CW'(1);
            end
            if (is_slot) begin
                rank_next = upd.new_rank[CW-1:0];
                if (upd.write_page) begin
                    page_next = upd.page[PAGE_BITS-1:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rank_reg        <= '0;
            probe_reg.valid <= 1'b0;
        end else begin
            rank_reg  <= rank_next;
            probe_reg <= probe_next;
        end
    end

    always_ff @(posedge aclk) begin
        page_reg <= page_next;
    end

    assign probe_out = probe_reg;

endmodule

/* hw/rtl/lru_page_replacement.sv */
// Top level of the LRU page replacement block: control, counters, result register.
// Depends on lrupr_pkg, lrupr_cell and lru_page_replacement_assert.svh.
//
//  channel   direction  handshake           payload
//  s_        in         s_tvalid/s_tready   s_tdata: page_number
//  m_        out        m_tvalid/m_tready   m_tdata: hit, frame_slot, evicted_valid,
//                                                    evicted_page, fault_count
//  cfg_      in         cfg_valid/cfg_ready cfg_data: frames_in_use
//
// Per item, the accept loads the search register, the search item passes through
// the register of each frame cell in turn, the result register latches it and
// the commit writes the output register; no new item is taken until the commit.
// The commit waits while an earlier result still sits in the output register.
// Frame-count writes are taken only while no item is in flight. Synchronous
// active-low reset clears ranks, fill count and fault total; frames_in_use is 3.
module lru_page_replacement #(
    parameter int FRAMES    = 8,
    parameter int PAGE_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,    // [15:0] page_number
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,    // [0] hit, [3:1] frame_slot, [4] evicted_valid,
                                    // [20:5] evicted_page, [52:21] fault_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data    // [3:0] frames_in_use
);
    import lrupr_pkg::*;

    localparam int CW = $clog2(FRAMES + 1);
    localparam int EW = (CW > 4) ? CW : 4;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_COMMIT = 3'b100
    } state_t;

    state_t         state_reg, state_next;
    logic [3:0]     cfg_reg, cfg_next;
    logic [CW-1:0]  filled_reg, filled_next;
    logic [31:0]    fault_reg, fault_next;
    probe_t         start_reg, start_next;
    probe_t         res_reg, res_next;
    probe_t         chain [FRAMES];
    upd_t           upd;

    logic           m_tvalid_reg, m_tvalid_next;
    logic [55:0]    m_tdata_reg, m_tdata_next;

    logic [EW-1:0]  cfg_ext;
    logic [EW-1:0]  active_wide;
    logic [CW-1:0]  active;
    logic [CW-1:0]  nv;
    logic           s_accept;
    logic           out_free;
    logic           commit;
    logic           do_fill;
    logic [SLOT_W-1:0] slot;
    logic           ev;
    logic [PAGE_W-1:0] evp;
    logic [CW-1:0]  filled_plus;

    // Active frame count: frames_in_use clamped to 1..FRAMES
    always_comb begin
        cfg_ext = EW'(cfg_reg);
        if (cfg_ext == '0) begin
            active_wide = EW'(1);
        end else if (cfg_ext > EW'(FRAMES)) begin
            active_wide = EW'(FRAMES);
        end else begin
            active_wide = cfg_ext;
        end
    end

    assign active      = CW'(active_wide);
    assign nv          = (filled_reg < active) ? filled_reg : active;
    assign filled_plus = filled_reg + CW'(1);

    // Hold frame-count writes off while an item walks the chain or waits to commit
    assign cfg_ready = state_reg == ST_IDLE;
    assign s_tready  = state_reg == ST_IDLE;
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign commit    = state_reg == ST_COMMIT && out_free;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            cfg_next = cfg_data;
        end
    end

    always_comb begin
        start_next       = '0;
        start_next.valid = s_accept;
        start_next.page  = PAGE_W'(PAGE_BITS'(s_tdata));
    end

    genvar gi;
    generate
        for (gi = 0; gi < FRAMES; gi++) begin : g_cell
            lrupr_cell #(
                .FRAMES    (FRAMES),
                .PAGE_BITS (PAGE_BITS),
                .INDEX     (gi)
            ) u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .nv        (nv),
                .probe_in  ((gi == 0) ? start_reg : chain[(gi == 0) ? 0 : gi - 1]),
                .probe_out (chain[gi]),
                .upd       (upd)
            );
        end
    endgenerate

    // Decide hit, fill or eviction from the finished search item
    always_comb begin
        do_fill = !res_reg.found && (filled_reg < active);
        ev      = !res_reg.found && !do_fill;
        evp     = ev ? res_reg.min_page : '0;

        upd            = '0;
        upd.en         = commit;
        upd.page       = res_reg.page;
        if (res_reg.found) begin
            slot           = res_reg.hit_slot;
            upd.promote    = 1'b1;
            upd.rank_ref   = res_reg.hit_rank;
            upd.new_rank   = RANK_W'(nv);
        end else if (do_fill) begin
            slot           = SLOT_W'(filled_reg);
            upd.write_page = 1'b1;
            upd.new_rank   = RANK_W'(filled_plus);
        end else begin
            slot           = res_reg.min_slot;
            upd.promote    = 1'b1;
            upd.write_page = 1'b1;
            upd.rank_ref   = res_reg.min_rank;
            upd.new_rank   = RANK_W'(nv);
        end
        upd.slot = slot;
    end

    always_comb begin
        state_next    = state_reg;
        res_next      = res_reg;
        filled_next   = filled_reg;
        fault_next    = fault_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (chain[FRAMES-1].valid) begin
                    res_next   = chain[FRAMES-1];
                    state_next = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (commit) begin
                    if (!res_reg.found && fault_reg != '1) begin
                        fault_next = fault_reg + 32'd1;
                    end
                    if (do_fill) begin
                        filled_next = filled_plus;
                    end
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'b000,
                                     (!res_reg.found && fault_reg != '1) ?
                                         fault_reg + 32'd1 : fault_reg,
                                     16'(evp),
                                     ev,
                                     3'(slot),
                                     res_reg.found};
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            cfg_reg         <= FRAMES_IN_USE_RESET;
            filled_reg      <= '0;
            fault_reg       <= '0;
            m_tvalid_reg    <= 1'b0;
            start_reg.valid <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cfg_reg      <= cfg_next;
            filled_reg   <= filled_next;
            fault_reg    <= fault_next;
            m_tvalid_reg <= m_tvalid_next;
            start_reg    <= start_next;
        end
    end

    always_ff @(posedge aclk) begin
        res_reg     <= res_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

`include "lru_page_replacement_assert.svh"

    `LRUPR_ASSERT_NOW(a_chain_in_scan, aclk, aresetn,
        chain[FRAMES-1].valid, state_reg == ST_SCAN,
        "search item left the chain outside a scan")
    `LRUPR_ASSERT_NEXT(a_hit_keeps_faults, aclk, aresetn,
        commit && res_reg.found, $stable(fault_reg) && $stable(filled_reg),
        "hit changed fault total or fill count")
    `LRUPR_ASSERT_NEXT(a_miss_counts, aclk, aresetn,
        commit && !res_reg.found && fault_reg != 32'hFFFF_FFFF,
        fault_reg == $past(fault_reg) + 32'd1,
        "miss did not advance fault total")
    `LRUPR_ASSERT_NEXT(a_result_loaded, aclk, aresetn,
        commit, m_tvalid_reg,
        "commit did not load a result")

endmodule

/* sim/lru_checker.sv */
`timescale 1ns / 100ps
// Checker for lru_page_replacement: watches the reference, result and frame-count
// channels, keeps its own LRU frame table and compares each result field by field.
// Depends on lrupr_pkg for the frame count that reset restores.
module lru_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,     // [15:0] page_number
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [55:0] m_tdata,     // [0] hit, [3:1] frame_slot, [4] evicted_valid,
                                     // [20:5] evicted_page, [52:21] fault_count
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [3:0]  cfg_data,    // [3:0] frames_in_use
    output int          mismatches,
    output int          outstanding
);

    localparam int NUM_FRAMES = 8;

    typedef struct {
        logic        hit;
        logic [2:0]  slot;
        logic        evicted;
        logic [15:0] evicted_page;
        logic [31:0] faults;
    } lookup_t;

    lookup_t     expected_lookups[$];
    logic [3:0]  frames_cfg;
    logic [15:0] resident[NUM_FRAMES];
    logic [3:0]  rank[NUM_FRAMES];
    int          filled;
    logic [31:0] fault_total;
    int          fail_total = 0;
    int          pending = 0;

    assign mismatches  = fail_total;
    assign outstanding = pending;

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        fail_total++;
        $display("[%0t] mismatch on %s: expected 0x%0h, got 0x%0h",
                 $time, what, want, got);
    endtask

    // Make slot the most recent among the first nv frames.
    task automatic promote_frame(input int slot, input int nv);
        logic [3:0] r;
        r = rank[slot];
        for (int k = 0; k < nv; k++) begin
            if (rank[k] > r) rank[k]--;
        end
        rank[slot] = 4'(nv);
    endtask

    task automatic reference_page(input logic [15:0] page, output lookup_t res);
        int act;
        int nv;
        int victim;
        act = (frames_cfg == 4'd0) ? 1 :
              (frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg);
        nv = (filled < act) ? filled : act;
        res.hit = 1'b0;
        res.slot = 3'd0;
        res.evicted = 1'b0;
        res.evicted_page = 16'd0;
        for (int k = 0; k < nv; k++) begin
            if (!res.hit && resident[k] == page) begin
                res.hit = 1'b1;
                res.slot = 3'(k);
            end
        end
        if (res.hit) begin
            promote_frame(int'(res.slot), nv);
        end else begin
            if (fault_total != 32'hFFFF_FFFF) fault_total++;
            if (filled < act) begin
                // still filling empty frames
                res.slot = 3'(filled);
                resident[filled] = page;
                filled++;
                rank[filled - 1] = 4'(filled);
            end else begin
                // lowest rank wins, lowest index on a tie
                victim = 0;
                for (int k = 1; k < nv; k++) begin
                    if (rank[k] < rank[victim]) victim = k;
                end
                res.slot = 3'(victim);
                res.evicted = 1'b1;
                res.evicted_page = resident[victim];
                resident[victim] = page;
                promote_frame(victim, nv);
            end
        end
        res.faults = fault_total;
    endtask

    always @(posedge aclk) begin
        lookup_t want;
        if (!aresetn) begin
            expected_lookups.delete();
            frames_cfg = lrupr_pkg::FRAMES_IN_USE_RESET;
            filled = 0;
            fault_total = 32'd0;
            for (int k = 0; k < NUM_FRAMES; k++) begin
                rank[k] = 4'd0;
                resident[k] = 16'd0;
            end
        end else begin
            if (cfg_valid && cfg_ready) frames_cfg = cfg_data;
            if (s_tvalid && s_tready) begin
                reference_page(s_tdata, want);
                expected_lookups.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                if (expected_lookups.size() == 0) begin
                    report_mismatch("result item with no reference pending", 32'd0,
                                    m_tdata[31:0]);
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_tdata[0] !== want.hit)
                        report_mismatch("hit", 32'(want.hit), 32'(m_tdata[0]));
                    if (m_tdata[3:1] !== want.slot)
                        report_mismatch("frame_slot", 32'(want.slot), 32'(m_tdata[3:1]));
                    if (m_tdata[4] !== want.evicted)
                        report_mismatch("evicted_valid", 32'(want.evicted), 32'(m_tdata[4]));
                    if (m_tdata[20:5] !== want.evicted_page)
                        report_mismatch("evicted_page", 32'(want.evicted_page),
                                        32'(m_tdata[20:5]));
                    if (m_tdata[52:21] !== want.faults)
                        report_mismatch("fault_count", want.faults, m_tdata[52:21]);
                    if (m_tdata[55:53] !== 3'd0)
                        report_mismatch("tdata padding", 32'd0, 32'(m_tdata[55:53]));
                end
            end
        end
        pending <= expected_lookups.size();
    end

endmodule

/* sim/tb_top.sv */
`timescale 1ns / 100ps
// Top of the lru_page_replacement testbench: clock, reset, page references,
// frame-count writes, result back-pressure and the verdict. Depends on lru_checker.
module tb_top;

    localparam int NUM_FRAMES = 8;
    localparam int RESULT_LATENCY = NUM_FRAMES + 4;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS = 125;

    logic        aclk;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = 16'd0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [55:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = 4'd0;
    int          mismatches;
    int          outstanding;
    int          burst_left = 0;
    int          ready_mode = 0;
    int          stall_cycle = 0;

    lru_page_replacement u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    lru_checker u_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #(5_000_000);
        $display("FAIL");
        $finish;
    end

    // Receiver: drive m_tready from a stall pattern that is picked anew at random.
    always @(posedge aclk) begin
        stall_cycle++;
        if (stall_cycle % 256 == 0) ready_mode = $urandom_range(0, 3);
        case (ready_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 1) == 1);
            2: m_tready <= (stall_cycle % 9 == 0);
            default: m_tready <= (stall_cycle % 4 != 3);
        endcase
    end

    // Send one page reference; gaps fall between bursts of random length.
    task automatic push_page(input logic [15:0] page);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= page;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Hold off until every result item is back, then let the block settle.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (outstanding != 0) @(posedge aclk);
        repeat (RESULT_LATENCY) @(posedge aclk);
    endtask

    task automatic write_frame_count(input logic [3:0] count);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_data  <= count;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial begin
        logic [3:0]  count;
        logic [15:0] pool_base;
        int          act;
        int          pool_n;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // three frames out of reset: fill, hit, then LRU evictions
        push_page(16'h0000); push_page(16'hFFFF); push_page(16'h0000);
        push_page(16'h0001); push_page(16'h0002); push_page(16'hFFFF);

        // grow to all frames: filling resumes, then a hit and an eviction
        write_frame_count(4'd8);
        push_page(16'h0010); push_page(16'h0020); push_page(16'h0040);
        push_page(16'h0080); push_page(16'h0100); push_page(16'h0001);
        push_page(16'h8000);

        // shrink: upper frames are ignored but keep their pages
        write_frame_count(4'd3);
        push_page(16'h0001); push_page(16'h0100); push_page(16'h0002);

        // zero acts as one frame
        write_frame_count(4'd0);
        push_page(16'h5555); push_page(16'hAAAA); push_page(16'hAAAA);

        // above range clamps to all frames
        write_frame_count(4'd15);
        push_page(16'h0020); push_page(16'h7FFF);

        write_frame_count(4'd1);
        push_page(16'h0000); push_page(16'h0000);

        // random phases: mostly a small working set near the frame count
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            count = (ph == 0) ? 4'd8 : (ph == 1) ? 4'd1 : 4'($urandom_range(0, 15));
            write_frame_count(count);
            act = (count == 4'd0) ? 1 : (count > NUM_FRAMES) ? NUM_FRAMES : int'(count);
            pool_n = act + $urandom_range(0, 3);
            pool_base = 16'($urandom);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 9) < 8)
                    push_page(pool_base + 16'($urandom_range(0, pool_n - 1)));
                else
                    push_page(16'($urandom));
            end
        end

        drain_results();
        if (mismatches == 0 && outstanding == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
